// ===== rtl/core/lcd_number_frame_builder_macros.svh =====
// Assertion macros shared by the checker of the LCD number frame builder.
`ifndef LCD_NUMBER_FRAME_BUILDER_MACROS_SVH
`define LCD_NUMBER_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LNFB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LNFB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lnfb_pkg.sv =====
// Package with widths, codes and segment tables of the LCD number frame builder.
`timescale 1ns / 1ps

package lnfb_pkg;

  localparam int OPCODE_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int POINT_W     = 4;
  localparam int BATT_W      = 2;
  localparam int CMD_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int MIN_DIGITS     = 2;

  // Divide by ten through a reciprocal multiply: floor(x * RECIP_10 / 2**35) == x / 10
  // for every 32-bit x.
  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [BYTE_W-1:0] WRITE_HEADER = 8'hA0;
  localparam logic [BYTE_W-1:0] BATTERY_MARK = 8'h80;
  localparam int                BATT_FIRST   = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_DEC  = 2'd0,
    OP_HEX  = 2'd1,
    OP_CMD  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIGIT_COUNT    = 2'd0,
    REG_SEGMENT_LAYOUT = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_HDR,
    S_RD,
    S_EMIT,
    S_TAIL,
    S_CMD0,
    S_CMD1
  } state_t;

  localparam logic [BYTE_W-1:0] SEG_STD [16] = '{
    8'h7D, 8'h60, 8'h3E, 8'h7A, 8'h63, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h4F, 8'h1D, 8'h6E, 8'h1F, 8'h17
  };
  localparam logic [BYTE_W-1:0] SEG_CLK [16] = '{
    8'hAF, 8'hA0, 8'hCB, 8'hE9, 8'hE4, 8'h6D, 8'h6F, 8'hA8,
    8'hEF, 8'hED, 8'hEE, 8'h67, 8'h0F, 8'hE3, 8'h4F, 8'h4E
  };

  function automatic logic [BYTE_W-1:0] seg_code(input logic layout, input logic [3:0] digit);
    return layout ? SEG_CLK[digit] : SEG_STD[digit];
  endfunction

  function automatic logic [BYTE_W-1:0] minus_code(input logic layout);
    return layout ? 8'h40 : 8'h02;
  endfunction

  function automatic logic [BYTE_W-1:0] point_code(input logic layout);
    return layout ? 8'h10 : 8'h80;
  endfunction

endpackage

// ===== rtl/core/lnfb_if.sv =====
// Handshake interfaces for the request, frame byte and configuration channels.
`timescale 1ns / 1ps

interface lnfb_req_if;
  import lnfb_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  number_value;
  logic [POINT_W-1:0]  point_position;
  logic                zero_fill;
  logic [BATT_W-1:0]   battery_level;
  logic [CMD_W-1:0]    command_code;

  modport source (output valid, opcode, number_value, point_position, zero_fill,
                  battery_level, command_code, input ready);
  modport sink   (input valid, opcode, number_value, point_position, zero_fill,
                  battery_level, command_code, output ready);
endinterface

interface lnfb_frame_if;
  import lnfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface lnfb_cfg_if;
  import lnfb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lcd_number_frame_builder.sv =====
// Top level: builds the serial byte frame for a segment LCD controller.
//
//   channel  dir  payload                                             one transaction
//   req      in   opcode, value, point, zero fill, battery, command   one request
//   frame    out  frame_byte, last_byte                               one frame byte
//   cfg      in   index, data                                         one register write
//
// A command request passes through S_CMD0 and S_CMD1 before the next request can be taken.
// A hex request writes one digit byte per cycle, then reads each stored byte back through S_RD
// and S_EMIT, with acceptance, header (S_HDR) and tail (S_TAIL) as steps of their own.
// A decimal request spends one divide-by-ten step in S_DIV before each digit write.
// Reset has no clearing pass; every number request writes all digit bytes before reading.
// A stall on frame holds the sequencer; the next request is taken once the tail byte is loaded.
`timescale 1ns / 1ps

module lcd_number_frame_builder #(
  parameter int MAX_DIGITS = lnfb_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  lnfb_req_if.sink       req,
  lnfb_frame_if.source   frame,
  lnfb_cfg_if.sink       cfg
);
  import lnfb_pkg::*;

  localparam int DEPTH = MAX_DIGITS + 2;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  logic [COUNT_W-1:0] digit_count;
  logic               layout;

  op_t                op;
  logic               neg;
  logic               fill;
  logic [POINT_W-1:0] point;
  logic [BATT_W-1:0]  batt;
  logic [CMD_W-1:0]   cmd;

  logic [VALUE_W-1:0]    bin;
  logic [VALUE_W-1:0]    quot;
  logic [PROD_W-1:0]     recip_prod;
  logic [3:0]            tens_lo;
  logic [3:0]            digit;
  logic [VALUE_W-1:0]    rest;
  logic [AW-1:0]         addr;
  logic                  ended;
  logic                  minus_next;
  logic                  prev_lsb;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] wdata;
  logic              wr_en;
  logic              rd_en;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_free;
  logic              load_out;
  logic [BYTE_W-1:0] load_byte;
  logic              load_last;

  logic               at_last;
  logic               rem_zero;
  logic               req_fire;
  logic [VALUE_W-1:0] mag_in;

  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign cfg.ready   = 1'b1;
  assign frame.valid = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.last_byte  = out_last;
  assign out_free    = !out_valid || frame.ready;

  assign at_last  = (COUNT_W'(addr) == digit_count);
  assign mag_in   = (op_t'(req.opcode) == OP_DEC && req.number_value[VALUE_W-1]) ?
                    (~req.number_value + VALUE_W'(1)) : req.number_value;

  // For a decimal request the quotient of bin by ten is registered in S_DIV; the digit is bin - 10 * quotient,
  // of which only the low four bits are needed.
  assign recip_prod = PROD_W'(bin) * PROD_W'(RECIP_10);
  assign tens_lo    = {quot[0], 3'b0} + {quot[2:0], 1'b0};
  assign digit      = (op == OP_DEC) ? (bin[3:0] - tens_lo) : bin[3:0];
  assign rest       = (op == OP_DEC) ? quot : {4'b0, bin[VALUE_W-1:4]};
  assign rem_zero   = (rest == '0);

  // Byte for the current digit position, with point and battery marks merged in.
  always_comb begin
    if (minus_next) begin
      wdata = minus_code(layout);
    end else if (ended) begin
      wdata = '0;
    end else begin
      wdata = seg_code(layout, digit);
    end
    if (op == OP_DEC && point != '0 && COUNT_W'(point) < digit_count &&
        COUNT_W'(addr) == COUNT_W'(point)) begin
      wdata = wdata | point_code(layout);
    end
    if (COUNT_W'(addr) >= COUNT_W'(BATT_FIRST) &&
        COUNT_W'(addr) < COUNT_W'(BATT_FIRST) + COUNT_W'(batt)) begin
      wdata = wdata | BATTERY_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    load_byte  = '0;
    load_last  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.opcode))
            OP_DEC:  state_next = S_DIV;
            OP_HEX:  state_next = S_WRITE;
            OP_CMD:  state_next = S_CMD0;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        wr_en = 1'b1;
        if (at_last) begin
          state_next = S_HDR;
        end else if (op == OP_DEC) begin
          state_next = S_DIV;
        end
      end
      S_HDR: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_byte  = WRITE_HEADER;
          state_next = S_RD;
        end
      end
      S_RD: begin
        rd_en      = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_byte  = {prev_lsb, rdata[BYTE_W-1:1]};
          state_next = at_last ? S_TAIL : S_RD;
        end
      end
      S_TAIL: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_byte  = {prev_lsb, 7'b0};
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CMD0: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_byte  = {1'b1, 2'b00, cmd[7:3]};
          state_next = S_CMD1;
        end
      end
      S_CMD1: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_byte  = {cmd[2:0], 5'b0};
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op         <= op_t'(req.opcode);
      neg        <= (op_t'(req.opcode) == OP_DEC) && req.number_value[VALUE_W-1];
      fill       <= req.zero_fill;
      point      <= req.point_position;
      batt       <= req.battery_level;
      cmd        <= req.command_code;
      bin        <= mag_in;
      quot       <= '0;
      addr       <= AW'(1);
      ended      <= 1'b0;
      minus_next <= 1'b0;
    end else begin
      case (state)
        S_DIV: begin
          quot <= VALUE_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);
        end
        S_WRITE: begin
          bin    <= rest;
          addr   <= at_last ? AW'(1) : addr + AW'(1);
          if (minus_next) begin
            minus_next <= 1'b0;
          end else if (!ended && rem_zero) begin
            // A negative number ends with its sign; zero fill only pads positives.
            if (neg) begin
              minus_next <= 1'b1;
              ended      <= 1'b1;
            end else if (!fill) begin
              ended <= 1'b1;
            end
          end
        end
        S_HDR: begin
          prev_lsb <= 1'b0;
        end
        S_EMIT: begin
          if (out_free) begin
            prev_lsb <= rdata[0];
            if (!at_last) begin
              addr <= addr + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_W'(MAX_DIGITS);
      layout      <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_DIGIT_COUNT: begin
          if (COUNT_W'(cfg.data) > COUNT_W'(MAX_DIGITS)) begin
            digit_count <= COUNT_W'(MAX_DIGITS);
          end else if (COUNT_W'(cfg.data) < COUNT_W'(MIN_DIGITS)) begin
            digit_count <= COUNT_W'(MIN_DIGITS);
          end else begin
            digit_count <= COUNT_W'(cfg.data);
          end
        end
        REG_SEGMENT_LAYOUT: layout <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/lnfb_checker.sv =====
// Port-level checker for the LCD number frame builder, bound to the top level.
`timescale 1ns / 1ps
`include "lcd_number_frame_builder_macros.svh"

module lnfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [lnfb_pkg::OPCODE_W-1:0] req_opcode,
  input logic                          frame_valid,
  input logic                          frame_ready,
  input logic [lnfb_pkg::BYTE_W-1:0]   frame_byte,
  input logic                          last_byte
);
  import lnfb_pkg::*;

  logic req_fire;
  logic stalled;

  assign req_fire = req_valid && req_ready;
  assign stalled  = frame_valid && !frame_ready;

  `LNFB_ASSERT_NXT(a_frame_valid_holds, clk, rst, stalled, frame_valid, "frame valid dropped while stalled")
  `LNFB_ASSERT_NXT(a_frame_payload_holds, clk, rst, stalled, $stable(frame_byte) && $stable(last_byte), "frame payload changed while stalled")
  `LNFB_ASSERT_NXT(a_busy_after_request, clk, rst, req_fire && req_opcode != OP_NONE, !req_ready, "request taken while a frame is in progress")
  `LNFB_ASSERT_NXT(a_unused_opcode_ignored, clk, rst, req_fire && req_opcode == OP_NONE, req_ready, "unused opcode left the block busy")

endmodule

bind lcd_number_frame_builder lnfb_checker u_lnfb_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_opcode  (req.opcode),
  .frame_valid (frame.valid),
  .frame_ready (frame.ready),
  .frame_byte  (frame.frame_byte),
  .last_byte   (frame.last_byte)
);
